FILE: rtl/load_based_freq_selector_core_macros.svh
// Assertion macros shared by the load based frequency selector RTL
`ifndef LOAD_BASED_FREQ_SELECTOR_CORE_MACROS_SVH
`define LOAD_BASED_FREQ_SELECTOR_CORE_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset
`define LBFS_ASSERT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset
`define LBFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/lbfs_pkg.sv
// Shared types and constants of the load based frequency selector
`default_nettype none

package lbfs_pkg;

   // Field widths
   localparam int FREQ_W   = 24;
   localparam int LOAD_W   = 7;
   localparam int CNT_W    = 32;
   localparam int CPU_W    = 3;
   localparam int SLOT_W   = 4;
   localparam int LEN_W    = 5;
   localparam int ENTRY_W  = FREQ_W + 1;
   localparam int NUMER_W  = CNT_W + LOAD_W;
   localparam int DIVCNT_W = 3;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FREQ  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LEN = 2'd2;

   localparam logic [FREQ_W-1:0] MIN_FREQ_RST  = '0;
   localparam logic [FREQ_W-1:0] MAX_FREQ_RST  = '1;
   localparam logic [LEN_W-1:0]  TABLE_LEN_RST = 5'd16;

   // Item kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_TABLE  = 1'b1;

   // Load scale and the reciprocal used for max_freq / 100
   localparam logic [LOAD_W-1:0] LOAD_SCALE = 7'd100;
   localparam int RECIP_W     = 25;
   localparam int RECIP_SHIFT = 31;
   localparam logic [RECIP_W-1:0] RECIP_100 = 25'd21474837;
   localparam int PROD_W      = FREQ_W + RECIP_W;
   localparam int Q100_W      = PROD_W - RECIP_SHIFT;
   localparam int SCALED_W    = LOAD_W + Q100_W;

   typedef struct packed {
      logic              req_type;
      logic [CPU_W-1:0]  cpu_index;
      logic [CNT_W-1:0]  idle_count;
      logic [CNT_W-1:0]  wall_count;
      logic              last_core;
      logic [FREQ_W-1:0] current_freq;
      logic [SLOT_W-1:0] entry_index;
      logic [FREQ_W-1:0] entry_freq;
      logic              entry_valid;
   } req_payload_type;

   typedef struct packed {
      logic [LOAD_W-1:0] core_load;
      logic              core_ignored;
      logic              round_done;
      logic              freq_change;
      logic [FREQ_W-1:0] chosen_freq;
      logic [CPU_W-1:0]  busiest_core;
   } rsp_payload_type;

   // Controller to datapath commands
   typedef struct packed {
      logic latch;
      logic tbl_write;
      logic prev_rd;
      logic delta;
      logic numer;
      logic div_step;
      logic peak;
      logic recip;
      logic scale;
      logic clamp;
      logic walk_rd;
      logic walk_eval;
      logic select;
      logic out_load;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_table;
      logic is_last;
      logic div_last;
      logic walk_end;
      logic walk_stop;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/lbfs_stream_if.sv
// Valid/ready stream interface carrying one payload item
`default_nettype none

interface lbfs_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: rtl/lbfs_ram.sv
// Generic single write port RAM with registered read
`default_nettype none

module lbfs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                      wr_data,
   input  wire logic                                  rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/lbfs_ctrl.sv
// Sequencer of the load based frequency selector
`default_nettype none
`include "load_based_freq_selector_core_macros.svh"

module lbfs_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   output logic                        in_ready,
   input  wire lbfs_pkg::dp_status_type status,
   output lbfs_pkg::dp_cmd_type         cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DISP   = 4'd1;
   localparam logic [3:0] ST_DELTA  = 4'd2;
   localparam logic [3:0] ST_NUMER  = 4'd3;
   localparam logic [3:0] ST_DIV    = 4'd4;
   localparam logic [3:0] ST_PEAK   = 4'd5;
   localparam logic [3:0] ST_RECIP  = 4'd6;
   localparam logic [3:0] ST_SCALE  = 4'd7;
   localparam logic [3:0] ST_CLAMP  = 4'd8;
   localparam logic [3:0] ST_WRD    = 4'd9;
   localparam logic [3:0] ST_WEVAL  = 4'd10;
   localparam logic [3:0] ST_SELECT = 4'd11;
   localparam logic [3:0] ST_FIN    = 4'd12;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISP;
            end
         end
         ST_DISP: begin
            if (status.is_table) begin
               cmd.tbl_write = 1'b1;
               state_in      = ST_FIN;
            end else begin
               cmd.prev_rd = 1'b1;
               state_in    = ST_DELTA;
            end
         end
         ST_DELTA: begin
            cmd.delta = 1'b1;
            state_in  = ST_NUMER;
         end
         ST_NUMER: begin
            cmd.numer = 1'b1;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_PEAK;
            end
         end
         ST_PEAK: begin
            cmd.peak = 1'b1;
            state_in = status.is_last ? ST_RECIP : ST_FIN;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_CLAMP;
         end
         ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = ST_WRD;
         end
         ST_WRD: begin
            if (status.walk_end) begin
               state_in = ST_SELECT;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WEVAL;
            end
         end
         ST_WEVAL: begin
            cmd.walk_eval = 1'b1;
            state_in      = status.walk_stop ? ST_SELECT : ST_WRD;
         end
         ST_SELECT: begin
            cmd.select = 1'b1;
            state_in   = ST_FIN;
         end
         ST_FIN: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `LBFS_ASSERT_NEXT(a_fin_to_idle, clock, reset, (state_ff == ST_FIN) && status.out_free, state_ff == ST_IDLE, "finished item did not return to idle")
   `LBFS_ASSERT_NEXT(a_div_to_peak, clock, reset, (state_ff == ST_DIV) && status.div_last, state_ff == ST_PEAK, "divider end did not advance to peak update")

endmodule

`default_nettype wire

FILE: rtl/lbfs_dpath.sv
// Datapath: counters, load divider, peak tracking, scaling and table walk
`default_nettype none
`include "load_based_freq_selector_core_macros.svh"

module lbfs_dpath #(
   parameter int NUM_CORES   = 8,
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lbfs_pkg::dp_cmd_type                 cmd,
   output lbfs_pkg::dp_status_type                   status,
   input  wire lbfs_pkg::req_payload_type            req_payload,
   output lbfs_pkg::rsp_payload_type                 rsp_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   input  wire logic                                 csr_wr_en,
   input  wire logic [lbfs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [lbfs_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int CORE_AW    = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
   localparam int CORE_EXT_W = CORE_AW + lbfs_pkg::CPU_W;
   localparam int TBL_AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SLOT_EXT_W = TBL_AW + lbfs_pkg::SLOT_W;
   localparam int IDX_CW     = ($clog2(TABLE_DEPTH + 1) > lbfs_pkg::LEN_W) ?
                               $clog2(TABLE_DEPTH + 1) : lbfs_pkg::LEN_W;
   localparam int PAIR_W     = 2 * lbfs_pkg::CNT_W;

   // Configuration registers
   logic [lbfs_pkg::FREQ_W-1:0] min_freq_ff, min_freq_in;
   logic [lbfs_pkg::FREQ_W-1:0] max_freq_ff, max_freq_in;
   logic [lbfs_pkg::LEN_W-1:0]  tbl_len_ff, tbl_len_in;

   // Control state
   logic [NUM_CORES-1:0]        core_vld_ff, core_vld_in;
   logic [lbfs_pkg::LOAD_W-1:0] peak_load_ff, peak_load_in;
   logic [lbfs_pkg::CPU_W-1:0]  peak_core_ff, peak_core_in;
   logic                        round_open_ff, round_open_in;
   logic                        rsp_valid_ff, rsp_valid_in;

   // Working registers
   lbfs_pkg::req_payload_type     req_ff, req_in;
   lbfs_pkg::rsp_payload_type     rsp_ff, rsp_in;
   logic                          prev_vld_ff, prev_vld_in;
   logic [lbfs_pkg::CNT_W-1:0]    di_ff, di_in;
   logic [lbfs_pkg::CNT_W-1:0]    dt_ff, dt_in;
   logic                          ign_ff, ign_in;
   logic [lbfs_pkg::NUMER_W-1:0]  rem_ff, rem_in;
   logic [lbfs_pkg::LOAD_W-1:0]   quo_ff, quo_in;
   logic [lbfs_pkg::DIVCNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [lbfs_pkg::Q100_W-1:0]   q100_ff, q100_in;
   logic [lbfs_pkg::SCALED_W-1:0] scaled_ff, scaled_in;
   logic [lbfs_pkg::FREQ_W-1:0]   want_ff, want_in;
   logic [lbfs_pkg::FREQ_W-1:0]   lo_ff, lo_in;
   logic [lbfs_pkg::FREQ_W-1:0]   hi_ff, hi_in;
   logic [lbfs_pkg::FREQ_W-1:0]   hit_ff, hit_in;
   logic [lbfs_pkg::FREQ_W-1:0]   nf_ff, nf_in;
   logic [IDX_CW-1:0]             idx_ff, idx_in;

   // Combinational helpers
   logic [CORE_EXT_W-1:0]         cpu_ext;
   logic [CORE_AW-1:0]            core_addr;
   logic                          cpu_ok;
   logic [SLOT_EXT_W-1:0]         slot_ext;
   logic                          slot_ok;
   logic [lbfs_pkg::CNT_W-1:0]    prev_idle;
   logic [lbfs_pkg::CNT_W-1:0]    prev_wall;
   logic [PAIR_W-1:0]             prev_rdata;
   logic [lbfs_pkg::CNT_W-1:0]    busy;
   logic [lbfs_pkg::NUMER_W-1:0]  busy_ext;
   logic [lbfs_pkg::NUMER_W-1:0]  div_shift;
   logic                          div_ge;
   logic [lbfs_pkg::LOAD_W-1:0]   base_load;
   logic [lbfs_pkg::CPU_W-1:0]    base_core;
   logic [lbfs_pkg::PROD_W-1:0]   recip_prod;
   logic [lbfs_pkg::SCALED_W-1:0] scale_prod;
   logic [lbfs_pkg::SCALED_W-1:0] lo_clamp;
   logic [IDX_CW-1:0]             walk_lim;
   logic [lbfs_pkg::ENTRY_W-1:0]  tbl_rdata;
   logic                          ent_vld;
   logic [lbfs_pkg::FREQ_W-1:0]   ent_freq;
   logic [lbfs_pkg::FREQ_W-1:0]   round_freq;

   // Core and slot range checks
   assign cpu_ext   = CORE_EXT_W'(req_ff.cpu_index);
   assign cpu_ok    = cpu_ext < CORE_EXT_W'(NUM_CORES);
   assign core_addr = cpu_ext[CORE_AW-1:0];
   assign slot_ext  = SLOT_EXT_W'(req_ff.entry_index);
   assign slot_ok   = slot_ext < SLOT_EXT_W'(TABLE_DEPTH);

   // Previous counters read as zero until the core is first written
   assign prev_idle = prev_vld_ff ? prev_rdata[PAIR_W-1:lbfs_pkg::CNT_W] : '0;
   assign prev_wall = prev_vld_ff ? prev_rdata[lbfs_pkg::CNT_W-1:0] : '0;

   // Busy time, widened for the times-100 numerator formed as 64 + 32 + 4
   assign busy     = dt_ff - di_ff;
   assign busy_ext = lbfs_pkg::NUMER_W'(busy);

   // One restoring division step, quotient bit from the top
   assign div_shift = lbfs_pkg::NUMER_W'(dt_ff) << div_cnt_ff;
   assign div_ge    = rem_ff >= div_shift;

   // Round start resets the peak to this sample
   assign base_load = round_open_ff ? peak_load_ff : '0;
   assign base_core = round_open_ff ? peak_core_ff : req_ff.cpu_index;

   // max_freq / 100 by reciprocal, then peak times that
   assign recip_prod = max_freq_ff * lbfs_pkg::RECIP_100;
   assign scale_prod = peak_load_ff * q100_ff;

   // Clamp: minimum first, maximum last
   assign lo_clamp = (scaled_ff < lbfs_pkg::SCALED_W'(min_freq_ff)) ?
                     lbfs_pkg::SCALED_W'(min_freq_ff) : scaled_ff;

   // Table walk limit
   assign walk_lim = (IDX_CW'(tbl_len_ff) > IDX_CW'(TABLE_DEPTH)) ?
                     IDX_CW'(TABLE_DEPTH) : IDX_CW'(tbl_len_ff);
   assign ent_vld  = tbl_rdata[lbfs_pkg::FREQ_W];
   assign ent_freq = tbl_rdata[lbfs_pkg::FREQ_W-1:0];

   // Result frequency only on the round closing sample
   assign round_freq = req_ff.last_core ? nf_ff : '0;

   // Status to the controller
   always_comb begin
      status           = '0;
      status.is_table  = req_ff.req_type == lbfs_pkg::REQ_TABLE;
      status.is_last   = req_ff.last_core;
      status.div_last  = div_cnt_ff == '0;
      status.walk_end  = idx_ff >= walk_lim;
      status.walk_stop = ent_vld && (ent_freq >= want_ff);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next values
   always_comb begin
      min_freq_in   = min_freq_ff;
      max_freq_in   = max_freq_ff;
      tbl_len_in    = tbl_len_ff;
      core_vld_in   = core_vld_ff;
      peak_load_in  = peak_load_ff;
      peak_core_in  = peak_core_ff;
      round_open_in = round_open_ff;
      rsp_valid_in  = rsp_valid_ff;
      req_in        = req_ff;
      rsp_in        = rsp_ff;
      prev_vld_in   = prev_vld_ff;
      di_in         = di_ff;
      dt_in         = dt_ff;
      ign_in        = ign_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      div_cnt_in    = div_cnt_ff;
      q100_in       = q100_ff;
      scaled_in     = scaled_ff;
      want_in       = want_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      hit_in        = hit_ff;
      nf_in         = nf_ff;
      idx_in        = idx_ff;

      // Configuration writes
      if (csr_wr_en) begin
         case (csr_index)
            lbfs_pkg::CSR_MIN_FREQ:  min_freq_in = csr_wr_data[lbfs_pkg::FREQ_W-1:0];
            lbfs_pkg::CSR_MAX_FREQ:  max_freq_in = csr_wr_data[lbfs_pkg::FREQ_W-1:0];
            lbfs_pkg::CSR_TABLE_LEN: tbl_len_in  = csr_wr_data[lbfs_pkg::LEN_W-1:0];
            default: ;
         endcase
      end

      if (cmd.latch) begin
         req_in = req_payload;
      end

      // Capture the valid flag alongside the counter read
      if (cmd.prev_rd) begin
         prev_vld_in = core_vld_ff[core_addr];
      end

      // Wrapped deltas; mark the core as written
      if (cmd.delta) begin
         di_in = req_ff.idle_count - prev_idle;
         dt_in = req_ff.wall_count - prev_wall;
         if (cpu_ok) begin
            core_vld_in[core_addr] = 1'b1;
         end
      end

      // Inconsistency check and divider setup
      if (cmd.numer) begin
         ign_in     = !cpu_ok || (dt_ff == '0) || (di_ff > dt_ff);
         rem_in     = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
         quo_in     = '0;
         div_cnt_in = lbfs_pkg::DIVCNT_W'(lbfs_pkg::LOAD_W - 1);
      end

      if (cmd.div_step) begin
         rem_in     = div_ge ? (rem_ff - div_shift) : rem_ff;
         quo_in     = {quo_ff[lbfs_pkg::LOAD_W-2:0], div_ge};
         div_cnt_in = div_cnt_ff - 1'b1;
      end

      // Peak tracking; the round closes on the last sample
      if (cmd.peak) begin
         if (!ign_ff && (quo_ff > base_load)) begin
            peak_load_in = quo_ff;
            peak_core_in = req_ff.cpu_index;
         end else begin
            peak_load_in = base_load;
            peak_core_in = base_core;
         end
         round_open_in = !req_ff.last_core;
      end

      if (cmd.recip) begin
         q100_in = recip_prod[lbfs_pkg::PROD_W-1:lbfs_pkg::RECIP_SHIFT];
      end

      if (cmd.scale) begin
         scaled_in = scale_prod;
      end

      // Clamp and start the walk
      if (cmd.clamp) begin
         want_in = (lo_clamp > lbfs_pkg::SCALED_W'(max_freq_ff)) ?
                   max_freq_ff : lo_clamp[lbfs_pkg::FREQ_W-1:0];
         lo_in   = '0;
         hi_in   = '0;
         hit_in  = '0;
         idx_in  = '0;
      end

      // Visit one table entry; invalid entries are skipped
      if (cmd.walk_eval) begin
         if (ent_vld) begin
            if (ent_freq < want_ff) begin
               lo_in = ent_freq;
            end
            if (ent_freq == want_ff) begin
               hit_in = ent_freq;
            end
            if (ent_freq > want_ff) begin
               hi_in = ent_freq;
            end
         end
         idx_in = idx_ff + IDX_CW'(1);
      end

      // Exact hit, else keep current if inside the bracket, else next higher
      if (cmd.select) begin
         if (hit_ff != '0) begin
            nf_in = hit_ff;
         end else if ((req_ff.current_freq >= lo_ff) && (req_ff.current_freq <= hi_ff)) begin
            nf_in = req_ff.current_freq;
         end else begin
            nf_in = hi_ff;
         end
      end

      // Output register
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = '0;
         if (req_ff.req_type == lbfs_pkg::REQ_SAMPLE) begin
            rsp_in.core_load    = ign_ff ? '0 : quo_ff;
            rsp_in.core_ignored = ign_ff;
            rsp_in.round_done   = req_ff.last_core;
            rsp_in.freq_change  = round_freq != '0;
            rsp_in.chosen_freq  = round_freq;
            rsp_in.busiest_core = peak_core_ff;
         end
      end
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_freq_ff   <= lbfs_pkg::MIN_FREQ_RST;
         max_freq_ff   <= lbfs_pkg::MAX_FREQ_RST;
         tbl_len_ff    <= lbfs_pkg::TABLE_LEN_RST;
         core_vld_ff   <= '0;
         peak_load_ff  <= '0;
         peak_core_ff  <= '0;
         round_open_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_freq_ff   <= min_freq_in;
         max_freq_ff   <= max_freq_in;
         tbl_len_ff    <= tbl_len_in;
         core_vld_ff   <= core_vld_in;
         peak_load_ff  <= peak_load_in;
         peak_core_ff  <= peak_core_in;
         round_open_ff <= round_open_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
      prev_vld_ff <= prev_vld_in;
      di_ff       <= di_in;
      dt_ff       <= dt_in;
      ign_ff      <= ign_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      div_cnt_ff  <= div_cnt_in;
      q100_ff     <= q100_in;
      scaled_ff   <= scaled_in;
      want_ff     <= want_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hit_ff      <= hit_in;
      nf_ff       <= nf_in;
      idx_ff      <= idx_in;
   end

   // Per-core previous idle and wall counters
   lbfs_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (NUM_CORES)
   ) u_prev_ram (
      .clock   (clock),
      .wr_en   (cmd.delta && cpu_ok),
      .wr_addr (core_addr),
      .wr_data ({req_ff.idle_count, req_ff.wall_count}),
      .rd_en   (cmd.prev_rd),
      .rd_addr (core_addr),
      .rd_data (prev_rdata)
   );

   // Frequency table: valid bit over kHz
   lbfs_ram #(
      .WIDTH (lbfs_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_tbl_ram (
      .clock   (clock),
      .wr_en   (cmd.tbl_write && slot_ok),
      .wr_addr (slot_ext[TBL_AW-1:0]),
      .wr_data ({req_ff.entry_valid, req_ff.entry_freq}),
      .rd_en   (cmd.walk_rd),
      .rd_addr (idx_ff[TBL_AW-1:0]),
      .rd_data (tbl_rdata)
   );

   assign rsp_payload = rsp_ff;
   assign rsp_valid   = rsp_valid_ff;

   `LBFS_ASSERT_HOLDS(a_load_range, clock, reset, rsp_valid_ff, rsp_ff.core_load <= lbfs_pkg::LOAD_SCALE, "core load above 100")
   `LBFS_ASSERT_HOLDS(a_ignored_zero, clock, reset, rsp_valid_ff && rsp_ff.core_ignored, rsp_ff.core_load == '0, "ignored sample with nonzero load")
   `LBFS_ASSERT_HOLDS(a_change_flag, clock, reset, rsp_valid_ff, rsp_ff.freq_change == (rsp_ff.chosen_freq != '0), "freq_change disagrees with chosen_freq")

endmodule

`default_nettype wire

FILE: rtl/load_based_freq_selector_core.sv
// Top level of the load based frequency selector
//
//   Channel   Dir  Handshake         Payload
//   req_chan  in   valid/ready       lbfs_pkg::req_payload_type
//   rsp_chan  out  valid/ready       lbfs_pkg::rsp_payload_type
//   csr_*     in   csr_wr_en only    csr_index, csr_wr_data
//
// One item at a time. A table write goes from dispatch straight to the
// output step; a load sample passes through the 7-step load divider. A
// round closing sample adds the reciprocal, scale and clamp steps, a walk
// (registered table RAM read, then compare, per entry) and the selection.
// reset is synchronous: configuration returns to its defaults and all
// cores read zero counters until sampled. A stalled result waits in the
// output register while the next item is taken and worked on.
`default_nettype none

module load_based_freq_selector_core #(
   parameter int NUM_CORES   = 8,
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lbfs_stream_if.sink                          req_chan,
   lbfs_stream_if.source                        rsp_chan,
   input  wire logic                            csr_wr_en,
   input  wire logic [lbfs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lbfs_pkg::CSR_DATA_W-1:0] csr_wr_data
);

   lbfs_pkg::dp_cmd_type    cmd;
   lbfs_pkg::dp_status_type status;

   // Sequencer
   lbfs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_chan.valid),
      .in_ready (req_chan.ready),
      .status   (status),
      .cmd      (cmd)
   );

   // Datapath with counter and table storage
   lbfs_dpath #(
      .NUM_CORES   (NUM_CORES),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_chan.payload),
      .rsp_payload (rsp_chan.payload),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

endmodule

`default_nettype wire
